@@ hw/rtl/sgb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

    localparam int RADIUS     = 2;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int NTAP       = 2 * RADIUS + 1;
    localparam int NSLOT      = 2 * RADIUS;
    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int SW         = $clog2(NTAP);
    localparam int PCW        = $clog2(RADIUS + 1);
    localparam int WW         = 12;
    localparam int HW         = 13;
    localparam int CW         = 17;
    localparam int DW         = 14;
    localparam int SUMW       = 9;
    localparam int PW         = CW + SUMW;
    localparam int ACW        = PW + $clog2(RADIUS + 1) + 1;
    localparam int HD         = 3;
    localparam int FDEPTH     = 8;
    localparam int FAW        = $clog2(FDEPTH);

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_COEF_C = 3'd2,
        CFG_COEF_1 = 3'd3,
        CFG_COEF_2 = 3'd4
    } t_cfg_idx;

    typedef logic [2:0][7:0] t_pix;
    typedef logic [NSLOT-1:0][2:0][7:0] t_entry;
    typedef logic [NTAP-1:0][2:0][7:0] t_taps;
    typedef logic [2:0][RADIUS:0][SUMW-1:0] t_sums;
    typedef logic [2:0][RADIUS:0][PW-1:0] t_prods;

    typedef struct packed {
        logic                      ov;
        logic                      last;
        logic [AW-1:0]             col;
        logic [NTAP-1:0][SW-1:0]   vsel;
    } t_ctl;

    typedef struct packed {
        t_pix pix;
        logic last;
    } t_out;

    // Tap position after border replication. dl and dr are the room to the
    // left (up) and right (down) of the center; fwd picks the index order.
    function automatic logic [SW-1:0] tap_sel(input int k, input logic [DW-1:0] dl,
                                              input logic [DW-1:0] dr, input logic fwd);
        int kk;
        kk = k;
        if (k > 0 && int'(dr) < k) kk = int'(dr);
        if (k < 0 && int'(dl) < -k) kk = -int'(dl);
        return fwd ? SW'(RADIUS + kk) : SW'(RADIUS - kk);
    endfunction

    function automatic logic [7:0] round_sat(input logic [ACW-1:0] acc);
        logic [ACW-1:0] t;
        t = acc + ACW'(32768);
        if (t[ACW-1:16] > (ACW-16)'(255)) return 8'hFF;
        return t[23:16];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/separable_gaussian_blur.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Each result passes the pipeline stage registers and then the output queue;
// the output stream trails the input by RADIUS rows plus RADIUS pixels.
// Throughput: one item per cycle, set by the single read-modify-write of the
// column line memory; input stalls once 8 results are pending downstream.
// Reset clears counters, pipeline valids and the output queue; the line
// memory keeps its contents and needs no clearing pass.
module separable_gaussian_blur
    import sgb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_stall,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_chan0,
    input  wire logic [7:0]    i_chan1,
    input  wire logic [7:0]    i_chan2,
    output      logic          o_valid,
    input  wire logic          i_stall,
    output      logic [7:0]    o_blur0,
    output      logic [7:0]    o_blur1,
    output      logic [7:0]    o_blur2,
    output      logic          o_frame_end,
    input  wire logic          i_cfg_valid,
    output      logic          o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [CW-1:0] i_cfg_data
);

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_coef_c, r_coef_1, r_coef_2;
    logic [RADIUS:0][CW-1:0] w_coef;
    logic [DW-1:0] w_w, w_h;

    logic [AW-1:0]  r_ic, n_ic, r_hc, n_hc;
    logic [HW-1:0]  r_ir, n_ir, r_hy, n_hy;
    logic           r_in_done, n_in_done;
    logic [PCW-1:0] r_pre, n_pre;

    logic w_acc, w_cnt, w_hact, w_ov, w_last, w_col_last;
    logic w_cfg_we, w_restart;
    logic [DW-1:0] w_r;

    t_taps r_sr, n_sr;
    t_sums w_hs, r_hs1, r_vs4;
    t_ctl  w_ctl, r_ctl1, r_ctl2, r_ctl3;
    t_prods r_hp2, r_vp5;
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic r_last4, r_last5;
    t_pix r_h3;
    t_entry r_mem [0:MAX_WIDTH-1];
    t_entry r_rd, r_rd2, r_rd3, w_cur, w_wr_entry;
    t_taps w_vtaps;
    t_sums w_vs;
    logic [2:0][ACW-1:0] w_hacc, w_vacc;

    logic [HD-1:0]          r_hist_v;
    logic [HD-1:0][AW-1:0]  r_hist_a;
    t_entry                 r_hist_d [0:HD-1];

    t_out r_fifo [0:FDEPTH-1];
    t_out w_push_d;
    logic [FAW-1:0] r_wp, r_rp;
    logic [FAW:0]   r_fcnt, r_cred;
    logic w_push, w_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_WIDTH ||
                                      t_cfg_idx'(i_cfg_index) == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(640);
            r_height <= HW'(480);
            r_coef_c <= CW'(26147);
            r_coef_1 <= CW'(15859);
            r_coef_2 <= CW'(3538);
        end else if (w_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[WW-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HW-1:0];
                CFG_COEF_C: r_coef_c <= i_cfg_data;
                CFG_COEF_1: r_coef_1 <= i_cfg_data;
                CFG_COEF_2: r_coef_2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int d = 0; d <= RADIUS; d++) begin
            if (d == 0)      w_coef[d] = r_coef_c;
            else if (d == 1) w_coef[d] = r_coef_1;
            else if (d == 2) w_coef[d] = r_coef_2;
            else             w_coef[d] = '0;
        end
        if (r_width == '0) w_w = DW'(1);
        else if (DW'(r_width) > DW'(MAX_WIDTH)) w_w = DW'(MAX_WIDTH);
        else w_w = DW'(r_width);
        if (r_height == '0) w_h = DW'(1);
        else if (DW'(r_height) > DW'(MAX_HEIGHT)) w_h = DW'(MAX_HEIGHT);
        else w_h = DW'(r_height);
    end

    // A drain beat during the pixel phase is dropped without any effect.
    assign w_acc      = i_valid && !o_stall;
    assign w_cnt      = w_acc && (r_in_done || !i_mode);
    assign w_hact     = (r_pre == PCW'(RADIUS));
    assign w_r        = DW'(r_hy) - DW'(RADIUS);
    assign w_ov       = w_hact && (DW'(r_hy) >= DW'(RADIUS));
    assign w_col_last = (DW'(r_hc) == w_w - DW'(1));
    assign w_last     = w_ov && w_col_last && (w_r == w_h - DW'(1));

    always_comb begin
        n_ic = r_ic; n_ir = r_ir; n_in_done = r_in_done;
        n_pre = r_pre; n_hc = r_hc; n_hy = r_hy;
        if (w_cnt) begin
            if (!r_in_done) begin
                if (DW'(r_ic) == w_w - DW'(1)) begin
                    n_ic = '0;
                    if (DW'(r_ir) == w_h - DW'(1)) n_in_done = 1'b1;
                    else n_ir = r_ir + HW'(1);
                end else begin
                    n_ic = r_ic + AW'(1);
                end
            end
            if (!w_hact) begin
                n_pre = r_pre + PCW'(1);
            end else if (w_col_last) begin
                n_hc = '0;
                n_hy = r_hy + HW'(1);
            end else begin
                n_hc = r_hc + AW'(1);
            end
            if (w_last) begin
                n_ic = '0; n_ir = '0; n_in_done = 1'b0;
                n_pre = '0; n_hc = '0; n_hy = '0;
            end
        end
        if (w_restart) begin
            n_ic = '0; n_ir = '0; n_in_done = 1'b0;
            n_pre = '0; n_hc = '0; n_hy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= '0; r_ir <= '0; r_in_done <= 1'b0;
            r_pre <= '0; r_hc <= '0; r_hy <= '0;
        end else begin
            r_ic <= n_ic; r_ir <= n_ir; r_in_done <= n_in_done;
            r_pre <= n_pre; r_hc <= n_hc; r_hy <= n_hy;
        end
    end

    // Horizontal taps come from the sample history, newest at index zero.
    always_comb begin
        logic [DW-1:0] dl_h, dr_h, dr_v;
        n_sr = r_sr;
        if (w_cnt) begin
            n_sr[0] = {i_chan2, i_chan1, i_chan0};
            for (int j = 1; j < NTAP; j++) n_sr[j] = r_sr[j-1];
        end
        dl_h = DW'(r_hc);
        dr_h = w_w - DW'(1) - DW'(r_hc);
        dr_v = w_h - DW'(1) - w_r;
        for (int ch = 0; ch < 3; ch++) begin
            w_hs[ch][0] = {1'b0, n_sr[tap_sel(0, dl_h, dr_h, 1'b0)][ch]};
            for (int d = 1; d <= RADIUS; d++) begin
                w_hs[ch][d] = SUMW'(n_sr[tap_sel(-d, dl_h, dr_h, 1'b0)][ch]) +
                              SUMW'(n_sr[tap_sel(d, dl_h, dr_h, 1'b0)][ch]);
            end
        end
        w_ctl.ov   = w_ov;
        w_ctl.last = w_last;
        w_ctl.col  = r_hc;
        for (int k = -RADIUS; k <= RADIUS; k++) begin
            w_ctl.vsel[k+RADIUS] = tap_sel(k, w_r, dr_v, 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= n_sr;
    end

    // Each memory entry holds one column of the last 2*RADIUS filtered rows.
    always_ff @(posedge i_clk) begin
        if (w_cnt && w_hact) r_rd <= r_mem[r_hc];
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_v) r_mem[r_ctl3.col] <= w_wr_entry;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_hacc[ch] = '0;
            w_vacc[ch] = '0;
            for (int d = 0; d <= RADIUS; d++) begin
                w_hacc[ch] = w_hacc[ch] + ACW'(r_hp2[ch][d]);
                w_vacc[ch] = w_vacc[ch] + ACW'(r_vp5[ch][d]);
            end
        end
    end

    // Writes issued after this item's read are picked up from the history;
    // with narrow frames the same column comes back within a few beats.
    always_comb begin
        w_cur = r_rd3;
        for (int i = HD - 1; i >= 0; i--) begin
            if (r_hist_v[i] && r_hist_a[i] == r_ctl3.col) w_cur = r_hist_d[i];
        end
        for (int i = 0; i < NSLOT - 1; i++) w_wr_entry[i] = w_cur[i+1];
        w_wr_entry[NSLOT-1] = r_h3;
        for (int i = 0; i < NSLOT; i++) w_vtaps[i] = w_cur[i];
        w_vtaps[NSLOT] = r_h3;
        for (int ch = 0; ch < 3; ch++) begin
            w_vs[ch][0] = {1'b0, w_vtaps[r_ctl3.vsel[RADIUS]][ch]};
            for (int d = 1; d <= RADIUS; d++) begin
                w_vs[ch][d] = SUMW'(w_vtaps[r_ctl3.vsel[RADIUS-d]][ch]) +
                              SUMW'(w_vtaps[r_ctl3.vsel[RADIUS+d]][ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hs1  <= w_hs;
        r_ctl1 <= w_ctl;
        r_ctl2 <= r_ctl1;
        r_rd2  <= r_rd;
        r_ctl3 <= r_ctl2;
        r_rd3  <= r_rd2;
        r_vs4  <= w_vs;
        r_last4 <= r_ctl3.last;
        r_last5 <= r_last4;
        for (int ch = 0; ch < 3; ch++) begin
            r_h3[ch] <= round_sat(w_hacc[ch]);
            for (int d = 0; d <= RADIUS; d++) begin
                r_hp2[ch][d] <= PW'(w_coef[d]) * PW'(r_hs1[ch][d]);
                r_vp5[ch][d] <= PW'(w_coef[d]) * PW'(r_vs4[ch][d]);
            end
        end
        if (r_s3_v) begin
            r_hist_d[0] <= w_wr_entry;
            for (int i = 1; i < HD; i++) r_hist_d[i] <= r_hist_d[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0;
            r_s4_v <= 1'b0; r_s5_v <= 1'b0;
            r_hist_v <= '0;
            r_hist_a <= '0;
        end else begin
            r_s1_v <= w_cnt && w_hact;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v && r_ctl3.ov;
            r_s5_v <= r_s4_v;
            if (r_s3_v) begin
                r_hist_v <= {r_hist_v[HD-2:0], 1'b1};
                r_hist_a <= {r_hist_a[HD-2:0], r_ctl3.col};
            end
        end
    end

    // Output queue; credits count every result from its input beat onward.
    assign w_push = r_s5_v;
    assign w_pop  = o_valid && !i_stall;
    always_comb begin
        w_push_d.last = r_last5;
        for (int ch = 0; ch < 3; ch++) w_push_d.pix[ch] = round_sat(w_vacc[ch]);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_fifo[r_wp] <= w_push_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_fcnt <= '0; r_cred <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + FAW'(1);
            if (w_pop)  r_rp <= r_rp + FAW'(1);
            r_fcnt <= r_fcnt + (FAW+1)'(w_push) - (FAW+1)'(w_pop);
            r_cred <= r_cred + (FAW+1)'(w_cnt && w_ov) - (FAW+1)'(w_pop);
        end
    end

    assign o_stall     = (r_cred == (FAW+1)'(FDEPTH));
    assign o_valid     = (r_fcnt != '0);
    assign o_blur0     = r_fifo[r_rp].pix[0];
    assign o_blur1     = r_fifo[r_rp].pix[1];
    assign o_blur2     = r_fifo[r_rp].pix[2];
    assign o_frame_end = r_fifo[r_rp].last;

    a_fifo_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_fcnt == (FAW+1)'(FDEPTH) && !w_pop))
        else $error("output queue overflow");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred >= r_fcnt)
        else $error("credit count below queue fill");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cnt && w_last) |=> (r_hy == '0 && r_pre == '0 && !r_in_done))
        else $error("frame counters not cleared after last pixel");

endmodule

`default_nettype wire
